>>> hdl/sli_pkg.sv
// ----------------------------------------------------------------------------
// Sorted list package
// Shared sizes, codes and the structs that travel between the top level and
// the storage cells of the sorted list.
// ----------------------------------------------------------------------------
package sli_pkg;

  localparam int CAPACITY = 16;
  localparam int DATA_W   = 32;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int OUT_CNT_W = 5;

  typedef enum logic {
    ACT_INSERT = 1'b0,
    ACT_DELETE = 1'b1
  } action_t;

  typedef enum logic [1:0] {
    STATUS_DONE      = 2'd0,
    STATUS_NOT_FOUND = 2'd1,
    STATUS_FULL      = 2'd2
  } status_t;

  // Broadcast to every cell for one accepted word.
  typedef struct packed {
    logic              en;
    logic              del;
    logic [DATA_W-1:0] value;
  } cmd_t;

  // What a cell shows its neighbors.
  typedef struct packed {
    logic              valid;
    logic              take;
    logic [DATA_W-1:0] value;
  } link_t;

  typedef struct packed {
    logic              valid;
    logic [DATA_W-1:0] value;
  } slot_t;

endpackage

>>> hdl/sli_cell.sv
// ----------------------------------------------------------------------------
// Sorted list cell
// Holds one slot of the sorted list and shifts toward or away from its
// neighbors when a value is inserted ahead of it or deleted at or ahead of it.
// ----------------------------------------------------------------------------
module sli_cell (
  input  logic          clk,
  input  logic          rst,
  input  sli_pkg::cmd_t  cmd,
  input  sli_pkg::link_t prev_link,
  input  sli_pkg::slot_t next_slot,
  output sli_pkg::link_t link,
  output sli_pkg::slot_t slot_next,
  output logic          match
);

  logic                       valid;
  logic [sli_pkg::DATA_W-1:0] value;
  logic                       ge;

  assign ge    = valid && ($signed(value) >= $signed(cmd.value));
  assign match = valid && (value == cmd.value);

  assign link.valid = valid;
  assign link.take  = !valid || ge;
  assign link.value = value;

  always_comb begin
    slot_next.valid = valid;
    slot_next.value = value;
    if (cmd.en) begin
      if (cmd.del) begin
        if (ge) begin
          slot_next.valid = next_slot.valid;
          slot_next.value = next_slot.value;
        end
      end else if (prev_link.take) begin
        slot_next.valid = valid || prev_link.valid;
        slot_next.value = prev_link.value;
      end else if (link.take) begin
        slot_next.valid = 1'b1;
        slot_next.value = cmd.value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= slot_next.valid;
    end
  end

  always_ff @(posedge clk) begin
    value <= slot_next.value;
  end

endmodule

>>> hdl/sorted_list_insert_delete.sv
// ----------------------------------------------------------------------------
// Sorted list with insert and delete
// Top level: a row of cells holding an ascending multiset, the entry count
// and a registered result word.
// ----------------------------------------------------------------------------
// The block takes one word per clock cycle and returns its result word in the
// following cycle from an output register; a new word is taken while the previous
// result waits, unless that result is stalled. The cycle is set by the compare
// that every cell does against the word's value and the equality flags that
// are gathered across the row to decide a delete. Inserts go in front of the
// first stored value that is greater or equal; a delete removes the first
// equal value. Reset clears the slot valid bits at once, so no clearing pass
// is needed.
module sorted_list_insert_delete (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        action,
  input  logic [31:0] item_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [4:0]  entry_count,
  output logic [31:0] smallest_value,
  output logic        store_empty
);

  localparam int N = sli_pkg::CAPACITY;

  sli_pkg::cmd_t  cmd;
  sli_pkg::link_t links   [N];
  sli_pkg::link_t prev_in [N];
  sli_pkg::slot_t next_in [N];
  sli_pkg::slot_t upd     [N];
  logic [N-1:0]   match_vec;
  logic [N-1:0]   valids;

  logic                        in_acc;
  logic                        is_del;
  logic                        full;
  logic                        found;
  logic                        apply;
  logic [sli_pkg::CNT_W-1:0]   count;
  logic [sli_pkg::CNT_W-1:0]   count_next;
  logic [sli_pkg::CNT_W+sli_pkg::OUT_CNT_W-1:0] count_ext;
  sli_pkg::status_t            status_next;

  assign in_stall = out_valid && out_stall;
  assign in_acc   = in_valid && !in_stall;
  assign is_del   = (action == sli_pkg::ACT_DELETE);
  assign full     = valids[N-1];
  assign found    = |match_vec;
  assign apply    = in_acc && (is_del ? found : !full);

  assign cmd.en    = apply;
  assign cmd.del   = is_del;
  assign cmd.value = item_value;

  for (genvar i = 0; i < N; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign prev_in[i] = '{valid: 1'b0, take: 1'b0, value: '0};
    end else begin : g_mid
      assign prev_in[i] = links[i-1];
    end
    if (i == N - 1) begin : g_last
      assign next_in[i] = '{valid: 1'b0, value: '0};
    end else begin : g_body
      assign next_in[i] = '{valid: links[i+1].valid, value: links[i+1].value};
    end

    sli_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .cmd       (cmd),
      .prev_link (prev_in[i]),
      .next_slot (next_in[i]),
      .link      (links[i]),
      .slot_next (upd[i]),
      .match     (match_vec[i])
    );

    assign valids[i] = links[i].valid;
  end

  always_comb begin
    count_next = count;
    if (apply) begin
      if (is_del) begin
        count_next = count - 1'b1;
      end else begin
        count_next = count + 1'b1;
      end
    end
  end

  always_comb begin
    if (is_del) begin
      status_next = found ? sli_pkg::STATUS_DONE : sli_pkg::STATUS_NOT_FOUND;
    end else begin
      status_next = full ? sli_pkg::STATUS_FULL : sli_pkg::STATUS_DONE;
    end
  end

  assign count_ext = {{sli_pkg::OUT_CNT_W{1'b0}}, count_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      count     <= '0;
    end else begin
      count <= count_next;
      if (in_acc) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      status         <= status_next;
      entry_count    <= count_ext[sli_pkg::OUT_CNT_W-1:0];
      smallest_value <= upd[0].valid ? upd[0].value : '0;
      store_empty    <= (count_next == '0);
    end
  end

`ifndef NO_ASSERTIONS
  a_valid_packed: assert property (@(posedge clk) disable iff (rst)
    ((valids + 1'b1) & valids) == '0)
    else $error("slot valid bits are not packed from the head");

  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    $countones(valids) == count)
    else $error("entry count disagrees with the valid slots");

  a_full_holds: assert property (@(posedge clk) disable iff (rst)
    (in_acc && !is_del && full) |=> ($stable(count) && $stable(valids)))
    else $error("refused insert changed the store");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> out_valid)
    else $error("accepted word produced no result");
`endif

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted list testbench
// Drives insert and delete words into the sorted list, keeps a shadow copy
// of the ascending multiset and checks every result word field by field.
// ----------------------------------------------------------------------------
typedef struct {
  sli_pkg::status_t           st;
  logic [4:0]                 cnt;
  logic [sli_pkg::DATA_W-1:0] low;
  logic                       empty;
} list_outcome_t;

class list_checker;
  logic signed [sli_pkg::DATA_W-1:0] held_values[$];
  list_outcome_t                     due_results[$];
  int mismatches;
  int inserts, deletes, refused, missed, full_hits, emptied;

  function new();
    mismatches = 0;
    inserts = 0;
    deletes = 0;
    refused = 0;
    missed = 0;
    full_hits = 0;
    emptied = 0;
  endfunction

  task report(string msg);
    if (mismatches < 25) $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  function int pending();
    return due_results.size();
  endfunction

  function logic [sli_pkg::DATA_W-1:0] any_held();
    return held_values[$urandom_range(0, held_values.size() - 1)];
  endfunction

  function void note_word(sli_pkg::action_t act, logic [sli_pkg::DATA_W-1:0] raw);
    logic signed [sli_pkg::DATA_W-1:0] v;
    list_outcome_t r;
    int pos;
    v = raw;
    pos = 0;
    if (act == sli_pkg::ACT_INSERT) begin
      inserts++;
      if (held_values.size() >= sli_pkg::CAPACITY) begin
        r.st = sli_pkg::STATUS_FULL;
        refused++;
      end else begin
        while (pos < held_values.size() && held_values[pos] < v) pos++;
        held_values.insert(pos, v);
        r.st = sli_pkg::STATUS_DONE;
        if (held_values.size() == sli_pkg::CAPACITY) full_hits++;
      end
    end else begin
      deletes++;
      while (pos < held_values.size() && held_values[pos] != v) pos++;
      if (pos >= held_values.size()) begin
        r.st = sli_pkg::STATUS_NOT_FOUND;
        missed++;
      end else begin
        held_values.delete(pos);
        r.st = sli_pkg::STATUS_DONE;
        if (held_values.size() == 0) emptied++;
      end
    end
    r.cnt = 5'(held_values.size());
    r.low = (held_values.size() != 0) ? held_values[0] : '0;
    r.empty = (held_values.size() == 0);
    due_results.push_back(r);
  endfunction

  task check_result(logic [1:0] st, logic [4:0] cnt,
                    logic [sli_pkg::DATA_W-1:0] low, logic emp);
    list_outcome_t r;
    if (due_results.size() == 0) begin
      report("result word arrived with nothing expected");
    end else begin
      r = due_results.pop_front();
      if (st !== r.st)
        report($sformatf("status %0d, expected %0d", st, r.st));
      if (cnt !== r.cnt)
        report($sformatf("entry_count %0d, expected %0d", cnt, r.cnt));
      if (low !== r.low)
        report($sformatf("smallest_value %h, expected %h", low, r.low));
      if (emp !== r.empty)
        report($sformatf("store_empty %b, expected %b", emp, r.empty));
    end
  endtask
endclass

module tb;
  localparam int RANDOM_WORDS = 600;
  localparam int LONG_HOLD    = 60;
  localparam int IDLE_LIMIT   = 2000;

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_stall;
  logic              action;
  logic [31:0]       item_value;
  logic              out_valid;
  logic              out_stall;
  logic [1:0]        status;
  logic [4:0]        entry_count;
  logic [31:0]       smallest_value;
  logic              store_empty;

  list_checker sb;
  int  words_sent;
  int  idle_cycles;
  int  hold_phase;
  bit  hold_req;
  bit  tx_steady;

  sorted_list_insert_delete dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .action         (action),
    .item_value     (item_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .entry_count    (entry_count),
    .smallest_value (smallest_value),
    .store_empty    (store_empty)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  function automatic int gap_len();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 6) return 0;
    if (roll < 9) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0, 1: return $urandom;
      2: begin
        case ($urandom_range(0, 3))
          0: return 32'h8000_0000;
          1: return 32'h7fff_ffff;
          2: return 32'h0000_0000;
          default: return 32'hffff_ffff;
        endcase
      end
      default: return $urandom_range(0, 16) - 8;
    endcase
  endfunction

  task automatic send_word(sli_pkg::action_t act, logic [31:0] v, int gap);
    in_valid <= 1'b1;
    action <= act;
    item_value <= v;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_word(act, v);
    words_sent++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_random(int insert_pct);
    int gap;
    gap = tx_steady ? 0 : gap_len();
    if ($urandom_range(1, 100) <= insert_pct)
      send_word(sli_pkg::ACT_INSERT, pick_value(), gap);
    else if (sb.held_values.size() > 0 && $urandom_range(0, 9) < 7)
      send_word(sli_pkg::ACT_DELETE, sb.any_held(), gap);
    else
      send_word(sli_pkg::ACT_DELETE, pick_value(), gap);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic run_directed();
    send_word(sli_pkg::ACT_DELETE, 32'h0000_0005, 0);
    send_word(sli_pkg::ACT_INSERT, 32'h7fff_ffff, 0);
    send_word(sli_pkg::ACT_INSERT, 32'h8000_0000, 1);
    send_word(sli_pkg::ACT_INSERT, 32'h0000_0000, 0);
    send_word(sli_pkg::ACT_INSERT, 32'hffff_ffff, 2);
    send_word(sli_pkg::ACT_INSERT, 32'h0000_0000, 0);
    send_word(sli_pkg::ACT_DELETE, 32'h0000_0005, 0);
    send_word(sli_pkg::ACT_DELETE, 32'h0000_0000, 0);
    for (int i = 0; i < 12; i++)
      send_word(sli_pkg::ACT_INSERT, 32'(i * 7 - 40), i % 2);
    send_word(sli_pkg::ACT_INSERT, 32'h0000_0001, 0);
    send_word(sli_pkg::ACT_DELETE, 32'h8000_0000, 0);
    send_word(sli_pkg::ACT_DELETE, 32'h7fff_ffff, 0);
    send_word(sli_pkg::ACT_DELETE, 32'h8000_0000, 0);
  endtask

  initial begin : receiver
    bit rx_steady;
    rx_steady = 1'b0;
    out_stall = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        hold_phase = 1;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        hold_phase = 2;
      end else begin
        if ($urandom_range(0, 19) == 0) rx_steady = !rx_steady;
        if (rx_steady) begin
          out_stall <= 1'b0;
          repeat ($urandom_range(10, 40)) @(posedge clk);
        end else if ($urandom_range(0, 9) < 6) begin
          out_stall <= 1'b0;
          repeat ($urandom_range(1, 6)) @(posedge clk);
        end else begin
          out_stall <= 1'b1;
          repeat ($urandom_range(0, 3) == 0 ? $urandom_range(8, 30) : $urandom_range(1, 3))
            @(posedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0)
      sb.check_result(status, entry_count, smallest_value, store_empty);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout: no word moved for %0d cycles", IDLE_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    int insert_pct;
    int phase_len;
    int phase;
    bit pressure_done;
    bit pause_done;
    int settle;
    sb = new();
    words_sent = 0;
    idle_cycles = 0;
    hold_phase = 0;
    hold_req = 1'b0;
    tx_steady = 1'b0;
    pressure_done = 1'b0;
    pause_done = 1'b0;
    phase = 0;
    rst = 1'b1;
    in_valid = 1'b0;
    action = sli_pkg::ACT_INSERT;
    item_value = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    run_directed();
    drain();

    while (words_sent < RANDOM_WORDS + 24) begin
      case (phase % 3)
        0: insert_pct = 80;
        1: insert_pct = 25;
        default: insert_pct = 50;
      endcase
      tx_steady = ($urandom_range(0, 3) == 0);
      phase_len = $urandom_range(30, 70);
      repeat (phase_len) send_random(insert_pct);
      phase++;
      if (!pressure_done && words_sent > 250) begin
        pressure_done = 1'b1;
        in_valid <= 1'b0;
        @(negedge clk) hold_req = 1'b1;
        @(posedge clk);
        while (hold_phase != 2) send_word(sli_pkg::ACT_INSERT, pick_value(), 0);
      end
      if (!pause_done && words_sent > 420) begin
        pause_done = 1'b1;
        drain();
      end
    end

    in_valid <= 1'b0;
    settle = 0;
    while (sb.pending() != 0 && settle < 1000) begin
      @(posedge clk);
      settle++;
    end
    repeat (8) @(posedge clk);
    if (sb.pending() != 0)
      sb.report($sformatf("%0d result words never arrived", sb.pending()));

    $display("Sent %0d words: %0d inserts (%0d refused as full), %0d deletes (%0d not found).",
             words_sent, sb.inserts, sb.refused, sb.deletes, sb.missed);
    $display("The store filled to %0d entries %0d times and emptied %0d times.",
             sli_pkg::CAPACITY, sb.full_hits, sb.emptied);
    if (sb.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

>>> filelist.f
hdl/sli_pkg.sv
hdl/sli_cell.sv
hdl/sorted_list_insert_delete.sv
sim/tb.sv
